// ----- src/mp1d_pkg.sv -----
// shared types, defaults and the float compare for the 1d max pooling stream core
// no dependencies
package mp1d_pkg;

    localparam int CHANNEL_MAX_DEF = 256;
    localparam int KERNEL_MAX_DEF  = 32;
    localparam int STRIDE_MAX_DEF  = 32;
    localparam int WIDTH_MAX_DEF   = 65536;
    localparam int ROWS_MAX_DEF    = 65536;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNELS  = 3'd0,
        CFG_ROW_WIDTH = 3'd1,
        CFG_STRIDE    = 3'd2,
        CFG_KERNEL    = 3'd3,
        CFG_ROWS      = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MOD,
        S_EMIT
    } state_t;

    // a > b as ieee single; any nan compares false, +0 and -0 are equal
    function automatic logic fp_greater(input logic [31:0] a, input logic [31:0] b);
        logic a_nan;
        logic b_nan;
        logic both_zero;
        logic res;
        a_nan     = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
        b_nan     = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
        both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
        if (a_nan || b_nan || both_zero)
            res = 1'b0;
        else if (!a[31] && b[31])
            res = 1'b1;
        else if (a[31] && !b[31])
            res = 1'b0;
        else if (!a[31])
            res = a[30:0] > b[30:0];
        else
            res = a[30:0] < b[30:0];
        return res;
    endfunction

endpackage

// ----- src/mp1d_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module mp1d_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// ----- src/max_pool_1d_stream_core.sv -----
// streaming 1d max pooling over float32 samples, position-major, channels innermost
// uses mp1d_pkg and mp1d_ram
//
// usage:
//   configure channels, row_width, stride, kernel and rows through the write port
//   (cfg_write, cfg_index, cfg_data) while idle; each write restarts the row,
//   position and channel counters. values are clamped into range on write.
//   samples enter on in_valid/in_ready, one item per sample; results leave on
//   out_valid/out_ready, one item per finished window and channel, ascending
//   window order, last_of_run marking the last result of a sample.
//   a sample steps through the windows open on it (about kernel/stride windows),
//   each a check and a read-modify-write, plus an emit per result, set by the
//   single read-modify-write path through the running-maximum ram. while a
//   sample is being worked on in_ready is low. the first result passes the
//   check, modify and emit states before it reaches the output register.
//   reset clears counters and restores default configuration; the maxima ram is
//   not cleared, every entry is written by a window's first sample before use.
//   a stalled receiver holds the output register and the block waits for it.
module max_pool_1d_stream_core
    import mp1d_pkg::*;
#(
    parameter int CHANNEL_MAX = CHANNEL_MAX_DEF,
    parameter int KERNEL_MAX  = KERNEL_MAX_DEF,
    parameter int STRIDE_MAX  = STRIDE_MAX_DEF,
    parameter int WIDTH_MAX   = WIDTH_MAX_DEF,
    parameter int ROWS_MAX    = ROWS_MAX_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [31:0]           sample_bits,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [31:0]           max_bits,
    output logic [15:0]           row_index,
    output logic [15:0]           out_position,
    output logic [7:0]            channel_index,
    output logic                  last_of_run,
    output logic                  batch_done
);

    localparam int CH_W   = $clog2(CHANNEL_MAX + 1);
    localparam int POS_W  = $clog2(WIDTH_MAX + STRIDE_MAX + KERNEL_MAX);
    localparam int OX_W   = $clog2(WIDTH_MAX + 1);
    localparam int ROW_W  = $clog2(ROWS_MAX + 1);
    localparam int ST_W   = $clog2(STRIDE_MAX + 1);
    localparam int K_W    = $clog2(KERNEL_MAX + 1);
    localparam int SLOT_W = $clog2(KERNEL_MAX);
    localparam int DEPTH  = KERNEL_MAX * CHANNEL_MAX;
    localparam int ADDR_W = $clog2(DEPTH);

    // configuration, clamped
    logic [CH_W-1:0]  chan_reg;
    logic [POS_W-1:0] width_reg;
    logic [ST_W-1:0]  stride_reg;
    logic [K_W-1:0]   kernel_reg;
    logic [ROW_W-1:0] rows_reg;

    // stream counters and window trackers
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [OX_W-1:0]   oldest_reg, oldest_next;
    logic [SLOT_W-1:0] oldest_slot_reg, oldest_slot_next;
    logic [POS_W-1:0]  oldest_start_reg, oldest_start_next;
    logic [OX_W-1:0]   started_reg, started_next;
    logic [POS_W-1:0]  nstart_reg, nstart_next;

    // candidate oldest window after this item
    logic [OX_W-1:0]   onx_reg, onx_next;
    logic [SLOT_W-1:0] onx_slot_reg, onx_slot_next;
    logic [POS_W-1:0]  onx_start_reg, onx_start_next;

    // loop iterator
    logic [OX_W-1:0]   ox_reg, ox_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [POS_W-1:0]  start_reg, start_next;

    logic [31:0] x_reg, x_next;
    logic [31:0] res_reg, res_next;
    logic        res_last_reg, res_last_next;
    logic        res_done_reg, res_done_next;

    state_t state_reg, state_next;

    // output register
    logic        ov_reg, ov_next;
    logic [31:0] omax_reg, omax_next;
    logic [15:0] orow_reg, orow_next;
    logic [15:0] opos_reg, opos_next;
    logic [7:0]  och_reg, och_next;
    logic        olast_reg, olast_next;
    logic        odone_reg, odone_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [31:0]       ram_wdata;
    logic [31:0]       ram_rdata;

    logic [31:0]       cfg_val;
    logic [POS_W-1:0]  w_last;
    logic [POS_W-1:0]  end_raw, end_cur;
    logic [POS_W-1:0]  nxt_start, end_raw_n, end_nxt;
    logic              ch_last;
    logic [SLOT_W-1:0] slot_inc;
    logic              out_free;

    mp1d_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (ram_wdata),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    assign ram_addr = ADDR_W'(slot_reg) * ADDR_W'(CHANNEL_MAX) + ADDR_W'(ch_reg);

    assign w_last    = width_reg - POS_W'(1);
    assign end_raw   = start_reg + POS_W'(kernel_reg) - POS_W'(1);
    assign end_cur   = (end_raw > w_last) ? w_last : end_raw;
    assign nxt_start = start_reg + POS_W'(stride_reg);
    assign end_raw_n = nxt_start + POS_W'(kernel_reg) - POS_W'(1);
    assign end_nxt   = (end_raw_n > w_last) ? w_last : end_raw_n;
    assign ch_last   = (ch_reg == chan_reg - CH_W'(1));
    assign slot_inc  = (slot_reg == SLOT_W'(KERNEL_MAX - 1)) ? '0 : slot_reg + SLOT_W'(1);
    assign out_free  = !ov_reg || out_ready;
    assign cfg_val   = 32'(cfg_data);

    // configuration with clamping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg   <= CH_W'(1);
            width_reg  <= POS_W'(1);
            stride_reg <= ST_W'(1);
            kernel_reg <= K_W'(2);
            rows_reg   <= ROW_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_CHANNELS:
                begin
                    if ((cfg_val & 32'h1ff) == 32'd0)
                        chan_reg <= CH_W'(1);
                    else if ((cfg_val & 32'h1ff) > 32'(CHANNEL_MAX))
                        chan_reg <= CH_W'(CHANNEL_MAX);
                    else
                        chan_reg <= CH_W'(cfg_val & 32'h1ff);
                end
                CFG_ROW_WIDTH:
                begin
                    if (cfg_val == 32'd0)
                        width_reg <= POS_W'(1);
                    else if (cfg_val > 32'(WIDTH_MAX))
                        width_reg <= POS_W'(WIDTH_MAX);
                    else
                        width_reg <= POS_W'(cfg_val);
                end
                CFG_STRIDE:
                begin
                    if ((cfg_val & 32'h3f) == 32'd0)
                        stride_reg <= ST_W'(1);
                    else if ((cfg_val & 32'h3f) > 32'(STRIDE_MAX))
                        stride_reg <= ST_W'(STRIDE_MAX);
                    else
                        stride_reg <= ST_W'(cfg_val & 32'h3f);
                end
                CFG_KERNEL:
                begin
                    if ((cfg_val & 32'h3f) < 32'd2)
                        kernel_reg <= K_W'(2);
                    else if ((cfg_val & 32'h3f) > 32'(KERNEL_MAX))
                        kernel_reg <= K_W'(KERNEL_MAX);
                    else
                        kernel_reg <= K_W'(cfg_val & 32'h3f);
                end
                CFG_ROWS:
                begin
                    if (cfg_val == 32'd0)
                        rows_reg <= ROW_W'(1);
                    else if (cfg_val > 32'(ROWS_MAX))
                        rows_reg <= ROW_W'(ROWS_MAX);
                    else
                        rows_reg <= ROW_W'(cfg_val);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            ch_reg           <= '0;
            pos_reg          <= '0;
            row_reg          <= '0;
            oldest_reg       <= '0;
            oldest_slot_reg  <= '0;
            oldest_start_reg <= '0;
            started_reg      <= '0;
            nstart_reg       <= '0;
            ov_reg           <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            ch_reg           <= ch_next;
            pos_reg          <= pos_next;
            row_reg          <= row_next;
            oldest_reg       <= oldest_next;
            oldest_slot_reg  <= oldest_slot_next;
            oldest_start_reg <= oldest_start_next;
            started_reg      <= started_next;
            nstart_reg       <= nstart_next;
            ov_reg           <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        onx_reg       <= onx_next;
        onx_slot_reg  <= onx_slot_next;
        onx_start_reg <= onx_start_next;
        ox_reg        <= ox_next;
        slot_reg      <= slot_next;
        start_reg     <= start_next;
        x_reg         <= x_next;
        res_reg       <= res_next;
        res_last_reg  <= res_last_next;
        res_done_reg  <= res_done_next;
        omax_reg      <= omax_next;
        orow_reg      <= orow_next;
        opos_reg      <= opos_next;
        och_reg       <= och_next;
        olast_reg     <= olast_next;
        odone_reg     <= odone_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        ch_next           = ch_reg;
        pos_next          = pos_reg;
        row_next          = row_reg;
        oldest_next       = oldest_reg;
        oldest_slot_next  = oldest_slot_reg;
        oldest_start_next = oldest_start_reg;
        started_next      = started_reg;
        nstart_next       = nstart_reg;
        onx_next          = onx_reg;
        onx_slot_next     = onx_slot_reg;
        onx_start_next    = onx_start_reg;
        ox_next           = ox_reg;
        slot_next         = slot_reg;
        start_next        = start_reg;
        x_next            = x_reg;
        res_next          = res_reg;
        res_last_next     = res_last_reg;
        res_done_next     = res_done_reg;
        ov_next           = ov_reg && !out_ready;
        omax_next         = omax_reg;
        orow_next         = orow_reg;
        opos_next         = opos_reg;
        och_next          = och_reg;
        olast_next        = olast_reg;
        odone_next        = odone_reg;
        ram_we            = 1'b0;
        ram_wdata         = x_reg;
        in_ready          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    x_next = sample_bits;
                    // a new window opens on the first channel of its start position
                    if (ch_reg == '0 && pos_reg == nstart_reg)
                    begin
                        started_next = started_reg + OX_W'(1);
                        nstart_next  = nstart_reg + POS_W'(stride_reg);
                    end
                    ox_next        = oldest_reg;
                    slot_next      = oldest_slot_reg;
                    start_next     = oldest_start_reg;
                    onx_next       = oldest_reg;
                    onx_slot_next  = oldest_slot_reg;
                    onx_start_next = oldest_start_reg;
                    state_next     = S_CHECK;
                end
            end

            S_CHECK:
            begin
                if (ox_reg < started_reg)
                    state_next = S_MOD;
                else
                begin
                    // item done: advance the stream counters
                    state_next = S_IDLE;
                    if (ch_last)
                    begin
                        ch_next = '0;
                        if (pos_reg == w_last)
                        begin
                            pos_next          = '0;
                            oldest_next       = '0;
                            oldest_slot_next  = '0;
                            oldest_start_next = '0;
                            started_next      = '0;
                            nstart_next       = '0;
                            row_next = (row_reg == rows_reg - ROW_W'(1)) ? '0
                                       : row_reg + ROW_W'(1);
                        end
                        else
                        begin
                            pos_next          = pos_reg + POS_W'(1);
                            oldest_next       = onx_reg;
                            oldest_slot_next  = onx_slot_reg;
                            oldest_start_next = onx_start_reg;
                        end
                    end
                    else
                        ch_next = ch_reg + CH_W'(1);
                end
            end

            S_MOD:
            begin
                ram_we = 1'b1;
                if (start_reg == pos_reg || fp_greater(x_reg, ram_rdata))
                    ram_wdata = x_reg;
                else
                    ram_wdata = ram_rdata;
                res_next      = ram_wdata;
                res_last_next = !((ox_reg + OX_W'(1) < started_reg) && (end_nxt == pos_reg));
                res_done_next = (row_reg == rows_reg - ROW_W'(1)) && (nxt_start > w_last)
                                && ch_last;
                if (ch_last && end_cur <= pos_reg)
                begin
                    onx_next       = ox_reg + OX_W'(1);
                    onx_slot_next  = slot_inc;
                    onx_start_next = nxt_start;
                end
                if (end_cur == pos_reg)
                    state_next = S_EMIT;
                else
                begin
                    ox_next    = ox_reg + OX_W'(1);
                    slot_next  = slot_inc;
                    start_next = nxt_start;
                    state_next = S_CHECK;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    omax_next  = res_reg;
                    orow_next  = 16'(row_reg);
                    opos_next  = 16'(ox_reg);
                    och_next   = 8'(ch_reg);
                    olast_next = res_last_reg;
                    odone_next = res_done_reg;
                    ox_next    = ox_reg + OX_W'(1);
                    slot_next  = slot_inc;
                    start_next = nxt_start;
                    state_next = S_CHECK;
                end
            end

            default: state_next = S_IDLE;
        endcase

        if (cfg_write)
        begin
            ch_next           = '0;
            pos_next          = '0;
            row_next          = '0;
            oldest_next       = '0;
            oldest_slot_next  = '0;
            oldest_start_next = '0;
            started_next      = '0;
            nstart_next       = '0;
        end
    end

    assign out_valid     = ov_reg;
    assign max_bits      = omax_reg;
    assign row_index     = orow_reg;
    assign out_position  = opos_reg;
    assign channel_index = och_reg;
    assign last_of_run   = olast_reg;
    assign batch_done    = odone_reg;

    a_oldest_le_started: assert property (@(posedge clk) disable iff (!rst_n)
        oldest_reg <= started_reg)
        else $error("oldest open window beyond started windows");

    a_open_fit_slots: assert property (@(posedge clk) disable iff (!rst_n)
        (started_reg - oldest_reg) <= OX_W'(KERNEL_MAX))
        else $error("more open windows than ram slots");

    a_pos_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < width_reg)
        else $error("position counter past row end");

    a_ch_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ch_reg < chan_reg)
        else $error("channel counter out of range");

    a_emit_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_free) |=> ov_reg)
        else $error("emitted result not in output register");

endmodule

// ----- dv/testbench.sv -----
// self-checking testbench for max_pool_1d_stream_core: predicts window maxima per item
// depends on mp1d_pkg (types, config indexes) and the core rtl
`timescale 1ns / 1ps

class pool_scoreboard;
    typedef struct packed {
        logic [31:0] max_bits;
        logic [15:0] row_index;
        logic [15:0] out_position;
        logic [7:0]  channel_index;
        logic        last_of_run;
        logic        batch_done;
    } pool_result_t;

    pool_result_t pending_maxima[$];
    logic [31:0]  running_max [32*256];
    int unsigned  n_channels, n_width, n_stride, n_kernel, n_rows;
    int unsigned  chan_cnt, pos_cnt, row_cnt, oldest_win, next_start, started_win;
    int           errors;
    int           results_seen;

    function new();
        errors = 0;
        results_seen = 0;
        n_channels = 1;
        n_width = 1;
        n_stride = 1;
        n_kernel = 2;
        n_rows = 1;
        restart();
    endfunction

    function void restart();
        chan_cnt = 0;
        pos_cnt = 0;
        row_cnt = 0;
        oldest_win = 0;
        next_start = 0;
        started_win = 0;
    endfunction

    static function int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function void set_register(mp1d_pkg::cfg_index_t idx, logic [16:0] v);
        case (idx)
            mp1d_pkg::CFG_CHANNELS:  n_channels = v[8:0];
            mp1d_pkg::CFG_ROW_WIDTH: n_width = v;
            mp1d_pkg::CFG_STRIDE:    n_stride = v[5:0];
            mp1d_pkg::CFG_KERNEL:    n_kernel = v[5:0];
            mp1d_pkg::CFG_ROWS:      n_rows = v;
            default: ;
        endcase
        restart();
    endfunction

    // float a > b on raw bits; nan never wins, signed zeros equal
    static function bit float_gt(logic [31:0] a, logic [31:0] b);
        bit an, bn;
        an = (a[30:23] == 8'hff) && (a[22:0] != 0);
        bn = (b[30:23] == 8'hff) && (b[22:0] != 0);
        if (an || bn) return 0;
        if (a[30:0] == 0 && b[30:0] == 0) return 0;
        if (a[31] != b[31]) return !a[31];
        if (!a[31]) return a[30:0] > b[30:0];
        return a[30:0] < b[30:0];
    endfunction

    function void note_sample(logic [31:0] xb);
        int unsigned c, w, s, k, r, ow, p, ch, ox, idx, e, n;
        pool_result_t res;
        c = clip(n_channels, 1, 256);
        w = clip(n_width, 1, 65536);
        s = clip(n_stride, 1, 32);
        k = clip(n_kernel, 2, 32);
        r = clip(n_rows, 1, 65536);
        ow = (w - 1) / s + 1;
        p = pos_cnt;
        ch = chan_cnt;
        n = 0;
        if (ch == 0 && p == next_start && started_win < ow) begin
            started_win++;
            next_start += s;
        end
        for (ox = oldest_win; ox < started_win; ox++) begin
            idx = (ox % 32) * 256 + ch;
            if (ox * s == p)
                running_max[idx] = xb;
            else if (float_gt(xb, running_max[idx]))
                running_max[idx] = xb;
            e = ox * s + k - 1;
            if (e > w - 1) e = w - 1;
            if (p == e) begin
                res.max_bits = running_max[idx];
                res.row_index = row_cnt[15:0];
                res.out_position = ox[15:0];
                res.channel_index = ch[7:0];
                res.last_of_run = 0;
                res.batch_done = (row_cnt == r - 1 && ox == ow - 1 && ch == c - 1);
                pending_maxima.push_back(res);
                n++;
            end
        end
        if (n > 0)
            pending_maxima[pending_maxima.size() - 1].last_of_run = 1;
        ch++;
        if (ch >= c) begin
            ch = 0;
            while (oldest_win < started_win) begin
                e = oldest_win * s + k - 1;
                if (e > w - 1) e = w - 1;
                if (e > p) break;
                oldest_win++;
            end
            p++;
            if (p >= w) begin
                p = 0;
                oldest_win = 0;
                started_win = 0;
                next_start = 0;
                row_cnt++;
                if (row_cnt >= r) row_cnt = 0;
            end
        end
        chan_cnt = ch;
        pos_cnt = p;
    endfunction

    function void check_result(pool_result_t got);
        pool_result_t want;
        results_seen++;
        if (pending_maxima.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            errors++;
            return;
        end
        want = pending_maxima.pop_front();
        if (want.max_bits != got.max_bits) begin
            $display("%0t: max_bits expected %h actual %h", $time, want.max_bits, got.max_bits);
            errors++;
        end
        if (want.row_index != got.row_index) begin
            $display("%0t: row_index expected %0d actual %0d", $time,
                     want.row_index, got.row_index);
            errors++;
        end
        if (want.out_position != got.out_position) begin
            $display("%0t: out_position expected %0d actual %0d", $time,
                     want.out_position, got.out_position);
            errors++;
        end
        if (want.channel_index != got.channel_index) begin
            $display("%0t: channel_index expected %0d actual %0d", $time,
                     want.channel_index, got.channel_index);
            errors++;
        end
        if (want.last_of_run != got.last_of_run) begin
            $display("%0t: last_of_run expected %0b actual %0b", $time,
                     want.last_of_run, got.last_of_run);
            errors++;
        end
        if (want.batch_done != got.batch_done) begin
            $display("%0t: batch_done expected %0b actual %0b", $time,
                     want.batch_done, got.batch_done);
            errors++;
        end
    endfunction
endclass

module testbench;
    import mp1d_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [16:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] sample_bits;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] max_bits;
    logic [15:0] row_index;
    logic [15:0] out_position;
    logic [7:0]  channel_index;
    logic        last_of_run;
    logic        batch_done;

    pool_scoreboard sb;
    bit  sink_idle_on;
    bit  src_idle_on;
    int  hold_off_cycles = 0;
    int  long_hold_requests = 0;
    int  long_hold_taken = 0;
    int  quiet_cycles = 0;
    int  items_sent;
    int  phases_run;

    max_pool_1d_stream_core dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .sample_bits(sample_bits),
        .out_valid(out_valid), .out_ready(out_ready),
        .max_bits(max_bits), .row_index(row_index), .out_position(out_position),
        .channel_index(channel_index), .last_of_run(last_of_run),
        .batch_done(batch_done)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // receiver: random stall bursts, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result({max_bits, row_index, out_position, channel_index,
                             last_of_run, batch_done});
        if (long_hold_taken != long_hold_requests)
        begin
            long_hold_taken <= long_hold_requests;
            hold_off_cycles <= 300;
            out_ready <= 1'b0;
        end
        else if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_ready <= 1'b0;
        end
        else if (!out_ready)
            out_ready <= 1'b1;
        else if (sink_idle_on && $urandom_range(0, 5) == 0)
        begin
            out_ready <= 1'b0;
            hold_off_cycles <= $urandom_range(0, 3);
        end
    end

    // watchdog on cycles with no accepted item on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic write_register(cfg_index_t idx, logic [16:0] v);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        sb.set_register(idx, v);
    endtask

    task automatic wait_drained();
        while (sb.pending_maxima.size() != 0)
            @(posedge clk);
        // a sample that emits nothing may still be in flight
        repeat (80) @(posedge clk);
    endtask

    task automatic send_sample(logic [31:0] v);
        int gap;
        if (src_idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample_bits <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_sample(v);
        items_sent++;
    endtask

    function automatic logic [31:0] random_float();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 7))
            0: v[30:23] = 8'hff;
            1: v[30:0] = 0;
            2: v[30:23] = 8'h00;
            default: v[30:23] = 8'($urandom_range(120, 134));
        endcase
        return v;
    endfunction

    task automatic configure(int unsigned ch, int unsigned w, int unsigned s,
                             int unsigned k, int unsigned r);
        in_valid <= 1'b0;
        wait_drained();
        write_register(CFG_CHANNELS, 17'(ch));
        write_register(CFG_ROW_WIDTH, 17'(w));
        write_register(CFG_STRIDE, 17'(s));
        write_register(CFG_KERNEL, 17'(k));
        write_register(CFG_ROWS, 17'(r));
        cfg_write <= 1'b0;
        phases_run++;
    endtask

    initial
    begin
        int n;
        int total;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        sample_bits = '0;
        out_ready = 1'b1;
        sb = new();
        sink_idle_on = 1'b0;
        src_idle_on = 1'b0;
        items_sent = 0;
        phases_run = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: default config, then extremes and special floats
        send_sample(32'h3f800000);
        send_sample(32'h7fc00000);
        send_sample(32'h80000000);
        send_sample(32'h00000000);
        configure(2, 5, 3, 2, 2);   // stride above kernel leaves gap positions
        send_sample(32'hffffffff);
        send_sample(32'h7f800000);
        send_sample(32'hff800000);
        send_sample(32'h00000001);
        send_sample(32'h7fffffff);
        send_sample(32'h80000001);
        for (n = 0; n < 14; n++)
            send_sample(random_float());
        // out of range values saturate
        configure(0, 0, 0, 0, 0);
        send_sample(32'h40000000);
        send_sample(32'hc0000000);
        configure(511, 3, 63, 63, 131071);
        for (n = 0; n < 20; n++)
            send_sample(random_float());

        sink_idle_on = 1'b1;
        src_idle_on = 1'b1;
        total = 0;
        while (total < 300)
        begin
            case (phases_run % 5)
                0: configure($urandom_range(1, 3), $urandom_range(1, 40), 1,
                             32, $urandom_range(1, 3));
                1: configure($urandom_range(1, 4), $urandom_range(1, 20),
                             $urandom_range(1, 8), $urandom_range(2, 8),
                             $urandom_range(1, 4));
                2: configure(256, 2, 32, 2, 1);
                3: configure(1, $urandom_range(30, 70), 32, 32, 2);
                default: configure($urandom_range(1, 8), $urandom_range(1, 16),
                                   $urandom_range(1, 4), $urandom_range(2, 6),
                                   $urandom_range(1, 3));
            endcase
            if (phases_run % 4 == 1)
                long_hold_requests++;
            n = $urandom_range(20, 80);
            repeat (n)
            begin
                send_sample(random_float());
                total++;
            end
            if (phases_run % 3 == 0)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (sb.pending_maxima.size() != 0)
                    @(posedge clk);
            end
        end

        // closing part with no idling
        sink_idle_on = 1'b0;
        src_idle_on = 1'b0;
        configure(3, 9, 2, 3, 2);
        for (n = 0; n < 60; n++)
            send_sample(random_float());
        in_valid <= 1'b0;
        wait_drained();

        $display("run covered %0d samples over %0d configurations, %0d results checked",
                 items_sent, phases_run, sb.results_seen);
        if (sb.errors == 0 && sb.pending_maxima.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule
